@@ sv/ymbr_pkg.sv @@
// ============================================================================
// ymbr_pkg: shared constants and types for the YMODEM block receiver
// Frame codes, result kinds, register indexes and the CRC unit control word.
// ============================================================================
package ymbr_pkg;

  // Data bytes carried by one SOH block.
  localparam int BLOCK_BYTES_DEF = 128;

  // Frame lead bytes and transmitted control bytes.
  localparam logic [7:0] LEAD_SOH = 8'h01;
  localparam logic [7:0] LEAD_EOT = 8'h04;
  localparam logic [7:0] TX_ACK   = 8'h06;
  localparam logic [7:0] TX_C     = 8'h43;

  // CRC-16 polynomial, MSB first, initial value zero.
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Update flag written at the top of the image region.
  localparam logic [31:0] FLAG_WORD = 32'hAAAAAAAA;

  // Reset value of the erase page count register.
  localparam logic [7:0] ERASE_PAGES_RESET = 8'd40;

  // Result kinds.
  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_PROG  = 2'd2;
  localparam logic [1:0] KIND_RESET = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_BASE  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_SIZE  = 2'd1;
  localparam logic [1:0] CFG_ERASE_PAGES = 2'd2;

  // Control from the frame sequencer to the serial CRC unit.
  typedef struct packed {
    logic start;
    logic clear;
  } crc_ctrl_t;

endpackage

@@ sv/ymbr_crc_serial.sv @@
// ============================================================================
// ymbr_crc_serial: bit-serial CRC-16 unit
// Folds one data byte into the running CRC, one bit per cycle, MSB first.
// ============================================================================
module ymbr_crc_serial (
  input  logic                clk,
  input  logic                rst,
  input  ymbr_pkg::crc_ctrl_t ctl,
  input  logic [7:0]          data,
  output logic [15:0]         crc,
  output logic                busy
);
  import ymbr_pkg::*;

  logic [7:0] shift;
  logic [2:0] count;
  logic       feedback;

  // Feedback is the CRC top bit against the next data bit.
  assign feedback = crc[15] ^ shift[7];

  // Clear between frames, load a byte on start, then shift eight times.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= '0;
      busy  <= 1'b0;
      count <= '0;
    end else if (ctl.clear) begin
      crc <= '0;
    end else if (ctl.start) begin
      shift <= data;
      count <= '0;
      busy  <= 1'b1;
    end else if (busy) begin
      crc   <= {crc[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
      shift <= {shift[6:0], 1'b0};
      count <= count + 3'd1;
      if (count == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  // A byte only starts when the unit is free.
  a_start_free : assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !busy) else $error("CRC start while busy");

  // The CRC is never cleared in the middle of a byte.
  a_clear_free : assert property (@(posedge clk) disable iff (rst)
    ctl.clear |-> !busy) else $error("CRC clear while busy");

  // Work begins only from a start request.
  a_busy_from_start : assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(ctl.start)) else $error("CRC busy without start");

endmodule

@@ sv/ymodem_block_receiver.sv @@
// ============================================================================
// ymodem_block_receiver: YMODEM-style receiver that writes an image to flash
// Collects frame bytes, checks CRC-16 and produces send, erase, program and
// reset words for the surrounding system.
// ============================================================================
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  --------------------------------
//  in       input      in_valid / in_stall      action, rx_byte, frame_end
//  out      output     out_valid / out_stall    kind, tx_byte, flash_address,
//                                               flash_word, last_result
//  cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A data byte holds the input until the eight steps of the bit-serial CRC
// unit are done. A frame end is judged in its own state; a data block then
// builds each program word from four reads of the block buffer, 33 result
// words in all with the closing ACK.
// Reset is synchronous and needs no clearing pass. A stalled output word
// holds the sequencer, and one finished word may wait while the next item
// is accepted.
//
module ymodem_block_receiver #(
  parameter int BLOCK_BYTES = ymbr_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input item channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic [31:0] flash_address,
  output logic [31:0] flash_word,
  output logic        last_result,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ymbr_pkg::*;

  localparam int         IDX_W      = $clog2(BLOCK_BYTES);
  localparam logic [7:0] POS_DATA   = 8'd3;
  localparam logic [7:0] POS_CRC_HI = 8'(BLOCK_BYTES + 3);
  localparam logic [7:0] POS_CRC_LO = 8'(BLOCK_BYTES + 4);
  localparam logic [7:0] POS_MAX    = 8'd255;

  typedef enum logic [3:0] {
    S_IDLE, S_CRC, S_EVAL, S_START_ACK, S_START_C, S_ERASE, S_ADDR, S_RD,
    S_RDW, S_PROG, S_BLK_ACK, S_FLAG_SUM, S_FLAG, S_RESET, S_POLL_C
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [31:0] addr;
    logic [31:0] word;
    logic        last;
  } result_t;

  state_t           state;
  result_t          res;
  logic [31:0]      image_base;
  logic [31:0]      image_size;
  logic [7:0]       erase_pages;
  logic             receiving_mode;
  logic [7:0]       block_counter;
  logic [7:0]       byte_position;
  logic [7:0]       lead_byte;
  logic [7:0]       block_number;
  logic [15:0]      received_crc;
  logic             end_pending;
  logic [31:0]      word_addr;
  logic [31:0]      word;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       mem_q;
  logic [7:0]       block_buffer [BLOCK_BYTES];
  crc_ctrl_t        crc_ctl;
  logic [15:0]      running_crc;
  logic             crc_busy;
  logic             in_accept;
  logic             is_data;
  logic             push_ok;
  logic             out_push;
  logic             frame_good;

  function automatic result_t make_result(logic [1:0] k, logic [7:0] t,
                                          logic [31:0] a, logic [31:0] w,
                                          logic l);
    result_t r;
    r.kind = k;
    r.tx   = t;
    r.addr = a;
    r.word = w;
    r.last = l;
    return r;
  endfunction

  // Handshake and decode of the current byte position.
  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign is_data    = (byte_position >= POS_DATA) && (byte_position < POS_CRC_HI);
  assign push_ok    = !out_valid || !out_stall;
  assign frame_good = (lead_byte == LEAD_SOH) && (byte_position >= POS_CRC_LO) &&
                      (running_crc == received_crc);

  // A result word is loaded in every emitting state once the register is free.
  assign out_push = push_ok &&
                    (state == S_START_ACK || state == S_START_C || state == S_ERASE ||
                     state == S_PROG || state == S_BLK_ACK || state == S_FLAG ||
                     state == S_RESET || state == S_POLL_C);

  // Result word on the output ports.
  assign kind          = res.kind;
  assign tx_byte       = res.tx;
  assign flash_address = res.addr;
  assign flash_word    = res.word;
  assign last_result   = res.last;

  // CRC unit starts on each data byte and clears when a frame is judged.
  assign crc_ctl.start = in_accept && !action && is_data;
  assign crc_ctl.clear = (state == S_EVAL);

  ymbr_crc_serial u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .data (rx_byte),
    .crc  (running_crc),
    .busy (crc_busy)
  );

  // Block buffer: written as data bytes arrive, read a byte at a time.
  always_ff @(posedge clk) begin
    if (crc_ctl.start) begin
      block_buffer[IDX_W'(byte_position - POS_DATA)] <= rx_byte;
    end
    mem_q <= block_buffer[rd_idx];
  end

  // Frame sequencer, configuration registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      image_base     <= '0;
      image_size     <= '0;
      erase_pages    <= ERASE_PAGES_RESET;
      receiving_mode <= 1'b0;
      block_counter  <= '0;
      byte_position  <= '0;
      lead_byte      <= '0;
      block_number   <= '0;
      received_crc   <= '0;
      end_pending    <= 1'b0;
      rd_idx         <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_IMAGE_BASE:  image_base  <= cfg_data;
          CFG_IMAGE_SIZE:  image_size  <= cfg_data;
          CFG_ERASE_PAGES: erase_pages <= cfg_data[7:0];
          default: ;
        endcase
      end

      // The output word leaves when the far side takes it and is replaced
      // whenever an emitting state fires.
      out_valid <= out_push || (out_valid && out_stall);

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (action) begin
              if (!receiving_mode) begin
                state <= S_POLL_C;
              end
            end else begin
              priority if (byte_position == 8'd0) begin
                lead_byte <= rx_byte;
              end else if (byte_position == 8'd1) begin
                block_number <= rx_byte;
              end else if (byte_position == POS_CRC_HI) begin
                received_crc[15:8] <= rx_byte;
              end else if (byte_position == POS_CRC_LO) begin
                received_crc[7:0] <= rx_byte;
              end else begin
              end
              if (!frame_end && byte_position != POS_MAX) begin
                byte_position <= byte_position + 8'd1;
              end
              end_pending <= frame_end;
              if (is_data) begin
                state <= S_CRC;
              end else if (frame_end) begin
                state <= S_EVAL;
              end
            end
          end
        end
        S_CRC: begin
          if (!crc_busy) begin
            state <= end_pending ? S_EVAL : S_IDLE;
          end
        end
        S_EVAL: begin
          byte_position <= '0;
          received_crc  <= '0;
          priority if (frame_good) begin
            if (receiving_mode) begin
              state <= S_ADDR;
            end else if (block_number == 8'd0) begin
              receiving_mode <= 1'b1;
              state          <= S_START_ACK;
            end else begin
              state <= S_IDLE;
            end
          end else if (lead_byte == LEAD_EOT) begin
            state <= S_FLAG_SUM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_START_ACK: begin
          if (push_ok) begin
            res   <= make_result(KIND_SEND, TX_ACK, '0, '0, 1'b0);
            state <= S_START_C;
          end
        end
        S_START_C: begin
          if (push_ok) begin
            res   <= make_result(KIND_SEND, TX_C, '0, '0, 1'b0);
            state <= S_ERASE;
          end
        end
        S_ERASE: begin
          if (push_ok) begin
            res   <= make_result(KIND_ERASE, 8'h00, image_base,
                                 {24'h000000, erase_pages}, 1'b1);
            state <= S_IDLE;
          end
        end
        // Block start address, then four byte reads per program word.
        S_ADDR: begin
          word_addr <= image_base + ({24'h000000, block_counter} << IDX_W);
          rd_idx    <= '0;
          state     <= S_RD;
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          word   <= {mem_q, word[31:8]};
          rd_idx <= rd_idx + 1'b1;
          state  <= (rd_idx[1:0] == 2'd3) ? S_PROG : S_RD;
        end
        S_PROG: begin
          if (push_ok) begin
            res       <= make_result(KIND_PROG, 8'h00, word_addr, word, 1'b0);
            word_addr <= word_addr + 32'd4;
            state     <= (rd_idx == '0) ? S_BLK_ACK : S_RD;
          end
        end
        S_BLK_ACK: begin
          if (push_ok) begin
            res           <= make_result(KIND_SEND, TX_ACK, '0, '0, 1'b1);
            block_counter <= block_counter + 8'd1;
            state         <= S_IDLE;
          end
        end
        // End of transfer: flag word at the top of the region, then reset.
        S_FLAG_SUM: begin
          word_addr <= image_base + image_size;
          state     <= S_FLAG;
        end
        S_FLAG: begin
          if (push_ok) begin
            res   <= make_result(KIND_PROG, 8'h00, word_addr - 32'd4,
                                 FLAG_WORD, 1'b0);
            state <= S_RESET;
          end
        end
        S_RESET: begin
          if (push_ok) begin
            res            <= make_result(KIND_RESET, 8'h00, '0, '0, 1'b1);
            receiving_mode <= 1'b0;
            block_counter  <= '0;
            lead_byte      <= '0;
            block_number   <= '0;
            state          <= S_IDLE;
          end
        end
        S_POLL_C: begin
          if (push_ok) begin
            res   <= make_result(KIND_SEND, TX_C, '0, '0, 1'b1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The CRC unit is idle whenever a new item can be taken.
  a_crc_idle : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !crc_busy) else $error("CRC busy while idle");

  // A program word is never the closing word of an item.
  a_prog_not_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_PROG) |-> !last_result)
    else $error("program word marked last");

  // A sent byte is ACK or C.
  a_tx_code : assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_SEND) |-> (tx_byte == TX_ACK || tx_byte == TX_C))
    else $error("bad transmit byte");

  // Receive mode is left only through the reset word.
  a_mode_exit : assert property (@(posedge clk) disable iff (rst)
    ($fell(receiving_mode) && !$past(rst)) |-> $past(state == S_RESET))
    else $error("receive mode left without reset word");

endmodule
